// File: rtl/core/esd_pkg.sv
// Shared types, codes and helpers for the escape sequence decoder.
`default_nettype none

package esd_pkg;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_HEX    = 2'd2,
		MODE_OCT    = 2'd3
	} mode_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_HEX   = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_TRAIL_BS = 2'd3;

	localparam logic [7:0] QUOTE_RESET = 8'd34;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_SEVEN    = 8'h37;
	localparam logic [7:0] CH_X        = 8'h78;
	localparam logic [7:0] CH_A        = 8'h61;
	localparam logic [7:0] CH_B        = 8'h62;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_N        = 8'h6E;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_V        = 8'h76;

	localparam logic [7:0] CODE_BEL = 8'd7;
	localparam logic [7:0] CODE_BS  = 8'd8;
	localparam logic [7:0] CODE_FF  = 8'd12;
	localparam logic [7:0] CODE_LF  = 8'd10;
	localparam logic [7:0] CODE_TAB = 8'd9;
	localparam logic [7:0] CODE_VT  = 8'd11;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       run_last;
		logic       string_end;
	} res_t;

	function automatic res_t mk_res(input logic has, input logic [7:0] b,
		input logic [1:0] st);
		res_t r;
		r.has_byte   = has;
		r.out_byte   = has ? b : 8'd0;
		r.status     = st;
		r.run_last   = 1'b0;
		r.string_end = 1'b0;
		return r;
	endfunction

	// Hex digit value in the low nibble, valid flag on top.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/escape_sequence_decoder.sv
// Escape sequence decoder: C-style escaped string in, decoded bytes out.
`default_nettype none

// Decodes one request (one input byte) per cycle while in_ready is high; the decode
// state and the result queue update in the cycle the request is taken. Results
// leave through a 4-entry queue, one per cycle while out_ready is high; a byte that
// ends a hex or octal escape and is itself emitted yields two results. in_ready is
// high while the queue holds at most two results, so the input side keeps one byte
// per cycle while the output side takes one result per cycle and no request yields
// two. quote_q is written through cfg_we/cfg_data and resets to 34.
module escape_sequence_decoder
	import esd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_string,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            has_byte,
	output logic [7:0]      out_byte,
	output logic [1:0]      status,
	output logic            run_last,
	output logic            string_end
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [7:0] quote_q;
	mode_t      mode_q, n_mode;
	logic [8:0] acc_q, n_acc;
	logic [1:0] cnt_q, n_cnt;
	logic       ovf_q, n_ovf;

	res_t          fifo_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	logic accept, pop;
	logic first_v, second_v;
	res_t first_r, second_r, r0, r1;
	logic [1:0] n_res;

	// normal-mode handling of the current byte
	logic norm_bs, norm_v, norm_esc;
	res_t norm_r;
	logic [4:0]  hd;
	logic [12:0] hex_sum;
	logic [11:0] oct_sum;
	logic [8:0]  oct_acc;
	logic        is_oct;
	res_t        hex_cur_r, oct_cur_r;

	assign accept = in_valid && in_ready;
	assign pop    = out_valid && out_ready;

	assign norm_bs  = (in_byte == CH_BSLASH);
	assign norm_v   = norm_bs ? end_of_string : (in_byte != quote_q);
	assign norm_r   = norm_bs ? mk_res(1'b0, 8'd0, ST_TRAIL_BS) : mk_res(1'b1, in_byte, ST_OK);
	assign norm_esc = norm_bs && !end_of_string;

	assign hd      = hex_digit(in_byte);
	assign hex_sum = {acc_q, 4'b0000} + {9'd0, hd[3:0]};
	assign is_oct  = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
	assign oct_sum = {acc_q, 3'b000} + {9'd0, 3'(in_byte - CH_ZERO)};
	assign oct_acc = oct_sum[8:0];

	// flush of the pending value as it stands before this byte
	assign hex_cur_r = (cnt_q == 2'd0) ? mk_res(1'b0, 8'd0, ST_NO_HEX) :
		(ovf_q || acc_q[8]) ? mk_res(1'b0, 8'd0, ST_RANGE) : mk_res(1'b1, acc_q[7:0], ST_OK);
	assign oct_cur_r = acc_q[8] ? mk_res(1'b0, 8'd0, ST_RANGE) :
		mk_res(1'b1, acc_q[7:0], ST_OK);

	always_comb begin
		n_mode   = mode_q;
		n_acc    = acc_q;
		n_cnt    = cnt_q;
		n_ovf    = ovf_q;
		first_v  = 1'b0;
		second_v = 1'b0;
		first_r  = mk_res(1'b0, 8'd0, ST_OK);
		second_r = mk_res(1'b0, 8'd0, ST_OK);
		unique case (mode_q)
			MODE_NORMAL: begin
				first_v = norm_v;
				first_r = norm_r;
				if (norm_esc) n_mode = MODE_ESC;
			end
			MODE_ESC: begin
				n_mode  = MODE_NORMAL;
				first_v = 1'b1;
				case (in_byte)
					CH_A: first_r = mk_res(1'b1, CODE_BEL, ST_OK);
					CH_B: first_r = mk_res(1'b1, CODE_BS, ST_OK);
					CH_F: first_r = mk_res(1'b1, CODE_FF, ST_OK);
					CH_N: first_r = mk_res(1'b1, CODE_LF, ST_OK);
					CH_T: first_r = mk_res(1'b1, CODE_TAB, ST_OK);
					CH_V: first_r = mk_res(1'b1, CODE_VT, ST_OK);
					CH_X: begin
						n_mode  = MODE_HEX;
						n_acc   = 9'd0;
						n_cnt   = 2'd0;
						n_ovf   = 1'b0;
						first_v = end_of_string;
						first_r = mk_res(1'b0, 8'd0, ST_NO_HEX);
					end
					default: begin
						if (is_oct) begin
							n_mode  = MODE_OCT;
							n_acc   = {6'd0, 3'(in_byte - CH_ZERO)};
							n_cnt   = 2'd1;
							n_ovf   = 1'b0;
							first_v = end_of_string;
							first_r = mk_res(1'b1, {5'd0, 3'(in_byte - CH_ZERO)}, ST_OK);
						end else begin
							first_r = mk_res(1'b1, in_byte, ST_OK);
						end
					end
				endcase
			end
			MODE_HEX: begin
				if (hd[4]) begin
					if (!ovf_q) begin
						if (|hex_sum[12:8]) n_ovf = 1'b1;
						else n_acc = hex_sum[8:0];
					end
					if (cnt_q != 2'd3) n_cnt = 2'(cnt_q + 2'd1);
					first_v = end_of_string;
					first_r = (n_ovf || n_acc[8]) ? mk_res(1'b0, 8'd0, ST_RANGE) :
						mk_res(1'b1, n_acc[7:0], ST_OK);
				end else begin
					n_mode   = norm_esc ? MODE_ESC : MODE_NORMAL;
					n_acc    = 9'd0;
					n_cnt    = 2'd0;
					n_ovf    = 1'b0;
					first_v  = 1'b1;
					first_r  = hex_cur_r;
					second_v = norm_v;
					second_r = norm_r;
				end
			end
			MODE_OCT: begin
				if (is_oct && cnt_q != 2'd3) begin
					n_acc   = oct_acc;
					n_cnt   = 2'(cnt_q + 2'd1);
					first_v = (cnt_q == 2'd2) || end_of_string;
					first_r = oct_acc[8] ? mk_res(1'b0, 8'd0, ST_RANGE) :
						mk_res(1'b1, oct_acc[7:0], ST_OK);
					if (cnt_q == 2'd2) begin
						n_mode = MODE_NORMAL;
						n_acc  = 9'd0;
						n_cnt  = 2'd0;
					end
				end else begin
					n_mode   = norm_esc ? MODE_ESC : MODE_NORMAL;
					n_acc    = 9'd0;
					n_cnt    = 2'd0;
					n_ovf    = 1'b0;
					first_v  = 1'b1;
					first_r  = oct_cur_r;
					second_v = norm_v;
					second_r = norm_r;
				end
			end
			default: n_mode = MODE_NORMAL;
		endcase
		if (end_of_string) begin
			n_mode = MODE_NORMAL;
			n_acc  = 9'd0;
			n_cnt  = 2'd0;
			n_ovf  = 1'b0;
			// empty result carries the end marker
			if (!first_v) begin
				first_v = 1'b1;
				first_r = mk_res(1'b0, 8'd0, ST_OK);
			end
		end
	end

	// tag the last result of this request
	always_comb begin
		r0 = first_r;
		r1 = second_r;
		if (second_v) begin
			r1.run_last   = 1'b1;
			r1.string_end = end_of_string;
			n_res         = 2'd2;
		end else begin
			r0.run_last   = 1'b1;
			r0.string_end = end_of_string;
			n_res         = {1'b0, first_v};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QUOTE_RESET;
		end else if (cfg_we) begin
			quote_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			acc_q  <= 9'd0;
			cnt_q  <= 2'd0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= n_mode;
			acc_q  <= n_acc;
			cnt_q  <= n_cnt;
			ovf_q  <= n_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
			if (n_res == 2'd2) fifo_q[PW'(wr_ptr_q + PW'(1))] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) wr_ptr_q <= PW'(wr_ptr_q + PW'(n_res));
			if (pop) rd_ptr_q <= PW'(rd_ptr_q + PW'(1));
			count_q <= CW'(count_q + (accept ? CW'(n_res) : CW'(0)) - (pop ? CW'(1) : CW'(0)));
		end
	end

	assign in_ready   = (count_q <= CW'(QUEUE_DEPTH - 2));
	assign out_valid  = (count_q != '0);
	assign has_byte   = fifo_q[rd_ptr_q].has_byte;
	assign out_byte   = fifo_q[rd_ptr_q].out_byte;
	assign status     = fifo_q[rd_ptr_q].status;
	assign run_last   = fifo_q[rd_ptr_q].run_last;
	assign string_end = fifo_q[rd_ptr_q].string_end;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_string) |=> (mode_q == MODE_NORMAL && acc_q == 9'd0 && !ovf_q))
		else $error("escape state left pending after end of string");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_end) |-> run_last)
		else $error("string end on a result that is not the last");

	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (!has_byte && out_byte == 8'd0))
		else $error("error result carries a byte");

endmodule

`default_nettype wire

// File: dv/escape_sequence_decoder_tb.sv
// Self-checking testbench for the escape sequence decoder: random strings, stalls, quote changes.
`timescale 1ns / 1ps

module escape_sequence_decoder_tb;
	import esd_pkg::*;

	localparam int STUCK_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 20;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR = 8'h34;

	typedef struct {
		logic [7:0] b;
		logic       eos;
	} enc_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'd0;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       has_byte;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       run_last;
	logic       string_end;

	enc_byte_t encoded_q[$];
	res_t      pending_decodes[$];
	res_t      step_q[$];

	// decoder model state
	mode_t      dec_mode = MODE_NORMAL;
	logic [8:0] dec_acc = 9'd0;
	logic [1:0] dec_digits = 2'd0;
	logic       dec_ovf = 1'b0;
	logic [7:0] quote_q = QUOTE_RESET;

	int gap_max = 0;
	int gap_left = 0;
	int burst_left = 0;
	logic [15:0] stall_mask = 16'd0;
	logic [3:0]  stall_pos = 4'd0;
	int stuck = 0;
	int fails = 0;
	int n_in = 0;
	int n_out = 0;
	int n_err = 0;
	int n_strings = 0;
	int n_quotes = 1;
	enc_byte_t nxt;
	res_t got;

	escape_sequence_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.has_byte(has_byte),
		.out_byte(out_byte),
		.status(status),
		.run_last(run_last),
		.string_end(string_end)
	);

	initial forever #6 clk = ~clk;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_A && c <= CH_F) return int'(c - CH_A) + 10;
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	task automatic emit(input logic has, input logic [7:0] b, input logic [1:0] st);
		res_t r;
		r.has_byte = has;
		r.out_byte = has ? b : 8'd0;
		r.status = st;
		r.run_last = 1'b0;
		r.string_end = 1'b0;
		step_q.push_back(r);
	endtask

	task automatic clear_escape();
		dec_mode = MODE_NORMAL;
		dec_acc = 9'd0;
		dec_digits = 2'd0;
		dec_ovf = 1'b0;
	endtask

	task automatic flush_hex();
		if (dec_digits == 2'd0) emit(1'b0, 8'd0, ST_NO_HEX);
		else if (dec_ovf || dec_acc > 9'd255) emit(1'b0, 8'd0, ST_RANGE);
		else emit(1'b1, dec_acc[7:0], ST_OK);
		clear_escape();
	endtask

	task automatic flush_oct();
		if (dec_acc > 9'd255) emit(1'b0, 8'd0, ST_RANGE);
		else emit(1'b1, dec_acc[7:0], ST_OK);
		clear_escape();
	endtask

	task automatic plain_byte(input logic [7:0] b, input logic eos);
		if (b == CH_BSLASH) begin
			if (eos) emit(1'b0, 8'd0, ST_TRAIL_BS);
			else dec_mode = MODE_ESC;
		end else if (b != quote_q) begin
			emit(1'b1, b, ST_OK);
		end
	endtask

	// Predict the results of one accepted request and queue them.
	task automatic decode_byte(input logic [7:0] b, input logic eos);
		int d;
		int v;
		res_t r;
		step_q.delete();
		case (dec_mode)
			MODE_NORMAL: plain_byte(b, eos);
			MODE_ESC: begin
				dec_mode = MODE_NORMAL;
				case (b)
					CH_A: emit(1'b1, CODE_BEL, ST_OK);
					CH_B: emit(1'b1, CODE_BS, ST_OK);
					CH_F: emit(1'b1, CODE_FF, ST_OK);
					CH_N: emit(1'b1, CODE_LF, ST_OK);
					CH_T: emit(1'b1, CODE_TAB, ST_OK);
					CH_V: emit(1'b1, CODE_VT, ST_OK);
					CH_X: begin
						clear_escape();
						dec_mode = MODE_HEX;
						if (eos) flush_hex();
					end
					default: begin
						if (b >= CH_ZERO && b <= CH_SEVEN) begin
							clear_escape();
							dec_mode = MODE_OCT;
							dec_acc = 9'(b - CH_ZERO);
							dec_digits = 2'd1;
							if (eos) flush_oct();
						end else begin
							emit(1'b1, b, ST_OK);
						end
					end
				endcase
			end
			MODE_HEX: begin
				d = hex_nibble(b);
				if (d >= 0) begin
					if (!dec_ovf) begin
						v = dec_acc * 16 + d;
						if (v > 255) dec_ovf = 1'b1;
						else dec_acc = 9'(v);
					end
					if (dec_digits < 2'd3) dec_digits++;
					if (eos) flush_hex();
				end else begin
					flush_hex();
					plain_byte(b, eos);
				end
			end
			default: begin
				if (b >= CH_ZERO && b <= CH_SEVEN && dec_digits < 2'd3) begin
					dec_acc = 9'(dec_acc * 8 + (b - CH_ZERO));
					dec_digits++;
					if (dec_digits >= 2'd3 || eos) flush_oct();
				end else begin
					flush_oct();
					plain_byte(b, eos);
				end
			end
		endcase
		if (eos) begin
			clear_escape();
			if (step_q.size() == 0) emit(1'b0, 8'd0, ST_OK);
		end
		if (step_q.size() > 0) begin
			r = step_q[step_q.size() - 1];
			r.run_last = 1'b1;
			r.string_end = eos;
			step_q[step_q.size() - 1] = r;
		end
		foreach (step_q[i]) pending_decodes.push_back(step_q[i]);
	endtask

	// Driver: present queued requests in bursts with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || encoded_q.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					nxt = encoded_q.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.b;
					end_of_string <= nxt.eos;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
					end
				end
			end
		end
	end

	// Receiver stalls follow a rotating mask; bit 0 stays clear so it never locks up.
	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= !stall_mask[stall_pos];
			stall_pos <= stall_pos + 4'd1;
		end
	end

	// Monitor: check results first, then predict from the request taken this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = res_t'({has_byte, out_byte, status, run_last, string_end});
				n_out++;
				if (status != ST_OK) n_err++;
				if (pending_decodes.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: unexpected result has=%0d byte=%02h st=%0d last=%0d end=%0d",
							$time, got.has_byte, got.out_byte, got.status, got.run_last,
							got.string_end);
				end else if (got !== pending_decodes[0]) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: mismatch exp has=%0d byte=%02h st=%0d last=%0d end=%0d %s",
							$time, pending_decodes[0].has_byte, pending_decodes[0].out_byte,
							pending_decodes[0].status, pending_decodes[0].run_last,
							pending_decodes[0].string_end,
							$sformatf("got has=%0d byte=%02h st=%0d last=%0d end=%0d",
								got.has_byte, got.out_byte, got.status, got.run_last,
								got.string_end));
					void'(pending_decodes.pop_front());
				end else begin
					void'(pending_decodes.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				n_in++;
				if (end_of_string) n_strings++;
				decode_byte(in_byte, end_of_string);
			end
			if ((out_valid && out_ready) || (in_valid && in_ready)) stuck <= 0;
			else stuck <= stuck + 1;
		end
	end

	initial begin
		while (stuck < STUCK_LIMIT) @(negedge clk);
		$display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic push_item(input logic [7:0] b, input logic eos);
		enc_byte_t it;
		it.b = b;
		it.eos = eos;
		encoded_q.push_back(it);
	endtask

	function automatic logic [7:0] esc_letter(input int i);
		case (i)
			0: return CH_A;
			1: return CH_B;
			2: return CH_F;
			3: return CH_N;
			4: return CH_T;
			default: return CH_V;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input int n);
		if (n < 10) return 8'(CH_ZERO + n);
		if ($urandom_range(0, 1)) return 8'(CH_A + n - 10);
		return 8'(CH_UPPER_A + n - 10);
	endfunction

	// Queue one string of random escape tokens, or now and then raw noise.
	task automatic queue_string(output int cnt);
		logic [7:0] s[$];
		int toks;
		int nd;
		if ($urandom_range(0, 9) == 0) begin
			nd = $urandom_range(1, 6);
			repeat (nd) push_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			cnt = nd;
			return;
		end
		toks = $urandom_range(1, 6);
		repeat (toks) begin
			case ($urandom_range(0, 9))
				0, 1, 2: s.push_back(8'($urandom_range(0, 255)));
				3: s.push_back(quote_q);
				4: begin
					s.push_back(CH_BSLASH);
					s.push_back(esc_letter($urandom_range(0, 5)));
				end
				5, 6: begin
					s.push_back(CH_BSLASH);
					s.push_back(CH_X);
					nd = $urandom_range(0, 4);
					repeat (nd) s.push_back(hex_char($urandom_range(0, 15)));
				end
				7: begin
					s.push_back(CH_BSLASH);
					nd = $urandom_range(1, 3);
					repeat (nd) s.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
				end
				8: begin
					s.push_back(CH_BSLASH);
					s.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					s.push_back(CH_BSLASH);
					s.push_back($urandom_range(0, 1) ? quote_q : CH_BSLASH);
				end
			endcase
		end
		// sometimes end on a lone backslash
		if ($urandom_range(0, 7) == 0) s.push_back(CH_BSLASH);
		for (int j = 0; j < s.size(); j++) push_item(s[j], j == s.size() - 1);
		cnt = s.size();
	endtask

	// Wait until every queued request is sent and every predicted result is out, then let the block settle.
	task automatic drain();
		while (encoded_q.size() != 0 || in_valid || pending_decodes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_quote(input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		quote_q = v;
		n_quotes++;
		@(negedge clk);
	endtask

	initial begin
		int n;
		int c;
		bit mid_done;
		logic [7:0] q;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: quote drop, byte extremes, hex/octal flushes, range errors, trailing escapes
		push_item(QUOTE_RESET, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_A, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_X, 1'b0);
		push_item(CH_FOUR, 1'b0);
		push_item(CH_ONE, 1'b0);
		push_item(CH_QMARK, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_X, 1'b0);
		push_item(CH_UPPER_F, 1'b0);
		push_item(CH_F, 1'b0);
		push_item(CH_UPPER_F, 1'b1);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_THREE, 1'b0);
		push_item(CH_SEVEN, 1'b0);
		push_item(CH_SEVEN, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_FOUR, 1'b0);
		push_item(CH_ZERO, 1'b0);
		push_item(CH_ZERO, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(QUOTE_RESET, 1'b0);
		push_item(CH_BSLASH, 1'b1);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_X, 1'b1);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: q = 8'd0;
				1: q = 8'd255;
				2: q = CH_BSLASH;
				5: q = QUOTE_RESET;
				default: q = 8'($urandom_range(0, 255));
			endcase
			write_quote(q);
			gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
			stall_mask = (ph % 3 == 1) ? 16'd0 : (16'($urandom) & 16'hFFFE);
			n = 0;
			mid_done = 0;
			while (n < 85) begin
				queue_string(c);
				n += c;
				if (!mid_done && n >= 40) begin
					drain();
					mid_done = 1;
				end
			end
			drain();
		end

		$display("sent %0d bytes in %0d strings under %0d quote settings", n_in, n_strings,
			n_quotes);
		$display("checked %0d results, %0d of them error reports", n_out, n_err);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
